FILE: rtl/q31alu_pkg.sv
package q31alu_pkg;

  // Operation codes carried on the cmd field; codes 9 to 15 are unused.
  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MULT  = 4'd2,
    CMD_ABS   = 4'd3,
    CMD_NEG   = 4'd4,
    CMD_MIN   = 4'd5,
    CMD_MAX   = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_SHIFT = 4'd8
  } cmd_t;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ShamtW    = 6;
  localparam int unsigned MulPre    = 12;
  localparam int unsigned MulOpW    = DataW - MulPre;
  localparam int unsigned ProdW     = 2 * MulOpW;
  localparam int unsigned PostShift = 7;

  localparam logic [ProdW:0]   MulRound = (ProdW + 1)'((1 << PostShift) - 1);
  localparam logic [DataW-1:0] Q31Max   = {1'b0, {(DataW - 1){1'b1}}};
  localparam logic [DataW-1:0] Q31Min   = {1'b1, {(DataW - 1){1'b0}}};

  // One request as held in the first pipeline stage.
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DataW-1:0]  a;
    logic signed [DataW-1:0]  b;
    logic signed [ShamtW-1:0] shamt;
  } op_req_t;

  // Redundant sign bits: leading zeros of the sign-folded word, minus one.
  // Zero and minus one fold to all zeros and give 31.
  function automatic logic [4:0] redundant_signs(logic [DataW-1:0] x);
    logic [DataW-1:0] v;
    logic [5:0]       lz;
    v  = x[DataW-1] ? ~x : x;
    lz = 6'd0;
    if (v[31:16] == 16'd0) begin
      lz = lz + 6'd16;
      v  = v << 16;
    end
    if (v[31:24] == 8'd0) begin
      lz = lz + 6'd8;
      v  = v << 8;
    end
    if (v[31:28] == 4'd0) begin
      lz = lz + 6'd4;
      v  = v << 4;
    end
    if (v[31:30] == 2'd0) begin
      lz = lz + 6'd2;
      v  = v << 2;
    end
    if (v[31] == 1'b0) begin
      lz = lz + 6'd1;
    end
    // An all-zero folded word has 32 leading zeros.
    if (v == '0) begin
      lz = 6'd32;
    end
    lz = lz - 6'd1;
    return lz[4:0];
  endfunction

endpackage

FILE: rtl/q31alu_mul.sv
module q31alu_mul (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [q31alu_pkg::DataW-1:0]    a,
  input  logic signed [q31alu_pkg::DataW-1:0]    b,
  output logic signed [q31alu_pkg::ProdW-1:0]    prod
);

  // Drop the low bits of each operand: arithmetic shift right by the preshift.
  logic signed [q31alu_pkg::MulOpW-1:0] pa;
  logic signed [q31alu_pkg::MulOpW-1:0] pb;

  assign pa = a[q31alu_pkg::DataW-1:q31alu_pkg::MulPre];
  assign pb = b[q31alu_pkg::DataW-1:q31alu_pkg::MulPre];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pa * pb;
    end
  end

endmodule

FILE: rtl/q31alu_ops.sv
module q31alu_ops (
  input  q31alu_pkg::op_req_t                   req,
  output logic signed [q31alu_pkg::DataW-1:0]   result
);

  logic [q31alu_pkg::DataW:0]           sum;
  logic [q31alu_pkg::DataW:0]           diff;
  logic                                 a_le_b;
  logic                                 a_is_min;
  logic [q31alu_pkg::ShamtW-1:0]        rmag;
  logic [4:0]                           ramt;
  logic signed [q31alu_pkg::DataW-1:0]  neg_a;

  // Clamp a 33-bit sum to the signed 32-bit range.
  function automatic logic [q31alu_pkg::DataW-1:0] sat33(logic [q31alu_pkg::DataW:0] v);
    logic [q31alu_pkg::DataW-1:0] r;
    if (v[q31alu_pkg::DataW] != v[q31alu_pkg::DataW-1]) begin
      r = v[q31alu_pkg::DataW] ? q31alu_pkg::Q31Min : q31alu_pkg::Q31Max;
    end else begin
      r = v[q31alu_pkg::DataW-1:0];
    end
    return r;
  endfunction

  assign sum      = {req.a[q31alu_pkg::DataW-1], req.a} + {req.b[q31alu_pkg::DataW-1], req.b};
  assign diff     = {req.a[q31alu_pkg::DataW-1], req.a} - {req.b[q31alu_pkg::DataW-1], req.b};
  assign a_le_b   = (req.a <= req.b);
  assign a_is_min = (req.a == q31alu_pkg::Q31Min);
  assign neg_a    = -req.a;

  // Right shift count is the magnitude of a negative amount, limited to 31.
  assign rmag = q31alu_pkg::ShamtW'(0) - req.shamt;
  assign ramt = rmag[q31alu_pkg::ShamtW-1] ? 5'd31 : rmag[4:0];

  always_comb begin
    case (req.cmd)
      q31alu_pkg::CMD_ADD:   result = sat33(sum);
      q31alu_pkg::CMD_SUB:   result = sat33(diff);
      q31alu_pkg::CMD_ABS:   result = a_is_min ? q31alu_pkg::Q31Max :
                                      (req.a[q31alu_pkg::DataW-1] ? neg_a : req.a);
      q31alu_pkg::CMD_NEG:   result = a_is_min ? q31alu_pkg::Q31Max : neg_a;
      q31alu_pkg::CMD_MIN:   result = a_le_b ? req.a : req.b;
      q31alu_pkg::CMD_MAX:   result = (req.a >= req.b) ? req.a : req.b;
      q31alu_pkg::CMD_NORM:  result = {27'd0, q31alu_pkg::redundant_signs(req.a)};
      q31alu_pkg::CMD_SHIFT: begin
        if (req.shamt[q31alu_pkg::ShamtW-1]) begin
          result = req.a >>> ramt;
        end else begin
          result = req.a << req.shamt[4:0];
        end
      end
      default:               result = '0;
    endcase
  end

endmodule

FILE: rtl/q31_saturating_alu.sv
// Channel    Valid/Ready             Payload
// request    req_valid / req_ready   cmd, operand_a, operand_b, shift_amount
// result     res_valid / res_ready   result
//
// Three register stages: request capture, execute (20x20 multiply or the
// other operations), then multiply rounding and result select into the
// output register. One request enters per cycle unless the result stalls.
// Synchronous active-high rst clears the stage valid bits only.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse under a stalled result and nothing is lost or repeated.
module q31_saturating_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic        [3:0]  cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic signed [5:0]  shift_amount,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] result
);

  // Stage 1: captured request.
  logic                s1_valid;
  q31alu_pkg::op_req_t s1_req;

  // Stage 2: raw product and the non-multiply result.
  logic                                  s2_valid;
  logic                                  s2_is_mult;
  logic signed [q31alu_pkg::DataW-1:0]   s2_misc;
  logic signed [q31alu_pkg::ProdW-1:0]   s2_prod;

  logic                                  adv1;
  logic                                  adv2;
  logic                                  adv3;
  logic signed [q31alu_pkg::DataW-1:0]   misc_next;
  logic [q31alu_pkg::ProdW:0]            rounded;

  // Advance chain from the output backward.
  assign adv3      = !res_valid || res_ready;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign req_ready = adv1;

  // Hold each request as one struct through the first stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= req_valid;
    end
    if (adv1 && req_valid) begin
      s1_req.cmd   <= q31alu_pkg::cmd_t'(cmd);
      s1_req.a     <= operand_a;
      s1_req.b     <= operand_b;
      s1_req.shamt <= shift_amount;
    end
  end

  q31alu_ops u_ops (
    .req    (s1_req),
    .result (misc_next)
  );

  // The multiplier keeps its own product register as part of stage 2.
  q31alu_mul u_mul (
    .clk  (clk),
    .en   (adv2 && s1_valid),
    .a    (s1_req.a),
    .b    (s1_req.b),
    .prod (s2_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2 && s1_valid) begin
      s2_is_mult <= (s1_req.cmd == q31alu_pkg::CMD_MULT);
      s2_misc    <= misc_next;
    end
  end

  // Round the product and keep 32 bits above the post-shift (wrapping).
  assign rounded = {s2_prod[q31alu_pkg::ProdW-1], s2_prod} + q31alu_pkg::MulRound;

  // Stage 3: output register; drop a result only once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv3) begin
      res_valid <= s2_valid;
    end
    if (adv3 && s2_valid) begin
      result <= s2_is_mult ? rounded[q31alu_pkg::PostShift +: q31alu_pkg::DataW] : s2_misc;
    end
  end

endmodule

FILE: rtl/q31_saturating_alu_chk.sv
module q31_saturating_alu_chk (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic signed [31:0] result
);

  // A stalled result holds its value until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // Requests are refused only when every stage is full and the output stalls.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid && !res_ready)
    else $error("request refused with room in the pipeline");

  // With res_ready high meanwhile, an accepted request passes through stage 1, stage 2 and the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready ##1 res_ready ##1 res_ready |=> res_valid)
    else $error("accepted request did not reach the output");

endmodule

bind q31_saturating_alu q31_saturating_alu_chk u_chk (.*);
